### sv/csfd_pkg.sv
// Shared types, widths and helpers for the CAN signal field decoder.
// Depends on nothing; used by can_signal_field_decoder.

package csfd_pkg;

    localparam int FRAME_BYTES_DEF = 8;

    localparam int PAYLOAD_W = 64;
    localparam int START_W   = 6;
    localparam int LEN_W     = 7;
    localparam int GAIN_W    = 32;
    localparam int BIAS_W    = 48;
    localparam int ACC_W     = PAYLOAD_W + GAIN_W;
    localparam int POS_W     = 7;
    localparam int CNT_W     = $clog2(GAIN_W);
    localparam int SUM_W     = 8;

    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(PAYLOAD_W);
    localparam logic [POS_W-1:0] POS_TOP  = POS_W'(PAYLOAD_W - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHK,
        ST_MUL,
        ST_DONE
    } t_state;

    // Reverse the bit order inside every byte, so sequential MSB-first
    // bit index b lands at word position b.
    function automatic logic [PAYLOAD_W-1:0] swap_in_bytes(input logic [PAYLOAD_W-1:0] w);
        logic [PAYLOAD_W-1:0] r;
        for (int k = 0; k < PAYLOAD_W; k++) begin
            r[k] = w[(k / 8) * 8 + 7 - (k % 8)];
        end
        return r;
    endfunction

endpackage

### sv/can_signal_field_decoder.sv
// CAN signal field decoder: bit-serial field and selector extraction,
// shift-add fixed-point scaling with 64-bit saturation. Depends on csfd_pkg.
//
// Usage: an input beat (i_valid/o_ready) carries one payload and one signal
// description; one result beat (o_valid/i_ready) carries o_ok, o_raw_value
// and o_scaled_value. o_ready is high only while no item is being decoded.
// The payload streams through a shift register one bit per cycle: Intel
// order scans bit 63 down to 0, sequential MSB-first order scans upward
// from bit 0 to bit 63 or to the last bit that a field or the selector touches,
// if that is later (up to 126 with larger FRAME_BYTES). A check state compares
// the selector, then a shift-add pass over the 32 gain bits forms raw*gain+bias.
// The steps run in order: scan, check, multiply, then the load of the output
// register, which waits while a previous result is still held.
// A bad range skips the scan, check and multiply: the item goes straight to the
// output load with zeros. A multiplexor mismatch skips the multiply.
// The result sits in an output register; a new beat is accepted while it
// waits, and a finished item holds until the receiver frees the register.
// Reset (synchronous, active low) returns to idle and drops a pending result.

module can_signal_field_decoder #(
    parameter int FRAME_BYTES = csfd_pkg::FRAME_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [csfd_pkg::PAYLOAD_W-1:0]      i_frame_payload,
    input  logic [csfd_pkg::START_W-1:0]        i_field_start,
    input  logic [csfd_pkg::LEN_W-1:0]          i_field_length,
    input  logic                                i_order_mode,
    input  logic                                i_sign_mode,
    input  logic                                i_mux_on,
    input  logic [csfd_pkg::START_W-1:0]        i_selector_start,
    input  logic [csfd_pkg::LEN_W-1:0]          i_selector_length,
    input  logic [csfd_pkg::PAYLOAD_W-1:0]      i_selector_match,
    input  logic signed [csfd_pkg::GAIN_W-1:0]  i_gain,
    input  logic signed [csfd_pkg::BIAS_W-1:0]  i_bias,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_ok,
    output logic signed [csfd_pkg::PAYLOAD_W-1:0] o_raw_value,
    output logic signed [csfd_pkg::PAYLOAD_W-1:0] o_scaled_value
);

    localparam int PW = csfd_pkg::PAYLOAD_W;
    localparam int AW = csfd_pkg::ACC_W;
    localparam int FrameBits = FRAME_BYTES * 8;

    csfd_pkg::t_state r_state, n_state;

    logic                          r_out_valid, n_out_valid;
    logic                          r_out_ok, n_out_ok;
    logic [PW-1:0]                 r_out_raw, n_out_raw;
    logic [PW-1:0]                 r_out_scaled, n_out_scaled;

    logic [csfd_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [PW-1:0]                 r_sh, n_sh;
    logic                          r_order, n_order;
    logic                          r_fill, n_fill;
    logic                          r_first, n_first;
    logic [csfd_pkg::START_W-1:0]  r_fstart, n_fstart;
    logic [csfd_pkg::POS_W-1:0]    r_fend, n_fend;
    logic                          r_mux, n_mux;
    logic [csfd_pkg::START_W-1:0]  r_sstart, n_sstart;
    logic [csfd_pkg::POS_W-1:0]    r_send, n_send;
    logic [csfd_pkg::POS_W-1:0]    r_last, n_last;
    logic [PW-1:0]                 r_fv, n_fv;
    logic [PW-1:0]                 r_sv, n_sv;
    logic [PW-1:0]                 r_match, n_match;
    logic [csfd_pkg::GAIN_W-1:0]   r_gn, n_gn;
    logic [csfd_pkg::BIAS_W-1:0]   r_bias, n_bias;
    logic [AW-1:0]                 r_acc, n_acc;
    logic [AW-1:0]                 r_mc, n_mc;
    logic [csfd_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_good, n_good;

    logic                          in_take;
    logic                          out_load;
    logic [csfd_pkg::SUM_W-1:0]    f_sum, s_sum;
    logic                          f_ok, s_ok, rng_ok;
    logic [csfd_pkg::POS_W-1:0]    f_end, s_end, last_pos;
    logic                          scan_end;
    logic                          scan_bit;
    logic                          in_f, in_s;
    logic                          mismatch;
    logic [AW-1:0]                 addend;
    logic [AW-PW:0]                acc_hi;
    logic                          acc_fits;
    logic [PW-1:0]                 sat_val;

    assign o_ready        = (r_state == csfd_pkg::ST_IDLE);
    assign in_take        = i_valid && o_ready;
    assign out_load       = (r_state == csfd_pkg::ST_DONE) && (!r_out_valid || i_ready);
    assign o_valid        = r_out_valid;
    assign o_ok           = r_out_ok;
    assign o_raw_value    = r_out_raw;
    assign o_scaled_value = r_out_scaled;

    always_comb begin
        f_sum  = csfd_pkg::SUM_W'(i_field_start) + csfd_pkg::SUM_W'(i_field_length);
        s_sum  = csfd_pkg::SUM_W'(i_selector_start) + csfd_pkg::SUM_W'(i_selector_length);
        f_ok   = (i_field_length != '0) && (i_field_length <= csfd_pkg::LEN_MAX) &&
                 (32'(f_sum) <= 32'(FrameBits));
        s_ok   = (i_selector_length != '0) && (i_selector_length <= csfd_pkg::LEN_MAX) &&
                 (32'(s_sum) <= 32'(FrameBits));
        rng_ok = f_ok && (!i_mux_on || s_ok);
        f_end  = csfd_pkg::POS_W'(f_sum - csfd_pkg::SUM_W'(1));
        s_end  = csfd_pkg::POS_W'(s_sum - csfd_pkg::SUM_W'(1));
        last_pos = csfd_pkg::POS_TOP;
        if (f_end > last_pos) begin
            last_pos = f_end;
        end
        if (i_mux_on && (s_end > last_pos)) begin
            last_pos = s_end;
        end
    end

    always_comb begin
        scan_bit = r_order ? r_sh[0] : r_sh[PW-1];
        scan_end = r_order ? (r_pos == r_last) : (r_pos == '0);
        in_f     = (r_pos >= csfd_pkg::POS_W'(r_fstart)) && (r_pos <= r_fend);
        in_s     = (r_pos >= csfd_pkg::POS_W'(r_sstart)) && (r_pos <= r_send);
        mismatch = r_mux && (r_sv != r_match);
        addend   = r_gn[0] ? r_mc : '0;
        acc_hi   = r_acc[AW-1:PW-1];
        acc_fits = (&acc_hi) || !(|acc_hi);
        if (acc_fits) begin
            sat_val = r_acc[PW-1:0];
        end else if (r_acc[AW-1]) begin
            sat_val = {1'b1, {(PW-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(PW-1){1'b1}}};
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            csfd_pkg::ST_IDLE: begin
                if (in_take) begin
                    n_state = rng_ok ? csfd_pkg::ST_SCAN : csfd_pkg::ST_DONE;
                end
            end
            csfd_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = csfd_pkg::ST_CHK;
                end
            end
            csfd_pkg::ST_CHK: begin
                n_state = mismatch ? csfd_pkg::ST_DONE : csfd_pkg::ST_MUL;
            end
            csfd_pkg::ST_MUL: begin
                if (r_cnt == csfd_pkg::CNT_LAST) begin
                    n_state = csfd_pkg::ST_DONE;
                end
            end
            csfd_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = csfd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = csfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_pos    = r_pos;
        n_sh     = r_sh;
        n_order  = r_order;
        n_fill   = r_fill;
        n_first  = r_first;
        n_fstart = r_fstart;
        n_fend   = r_fend;
        n_mux    = r_mux;
        n_sstart = r_sstart;
        n_send   = r_send;
        n_last   = r_last;
        n_fv     = r_fv;
        n_sv     = r_sv;
        n_match  = r_match;
        n_gn     = r_gn;
        n_bias   = r_bias;
        n_acc    = r_acc;
        n_mc     = r_mc;
        n_cnt    = r_cnt;
        n_good   = r_good;

        n_out_valid  = r_out_valid;
        n_out_ok     = r_out_ok;
        n_out_raw    = r_out_raw;
        n_out_scaled = r_out_scaled;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            csfd_pkg::ST_IDLE: begin
                if (in_take) begin
                    n_order  = i_order_mode;
                    n_sh     = i_order_mode ? csfd_pkg::swap_in_bytes(i_frame_payload)
                                            : i_frame_payload;
                    n_pos    = i_order_mode ? '0 : csfd_pkg::POS_TOP;
                    n_fill   = i_sign_mode && (i_order_mode || (f_end <= csfd_pkg::POS_TOP));
                    n_first  = 1'b1;
                    n_fstart = i_field_start;
                    n_fend   = f_end;
                    n_mux    = i_mux_on;
                    n_sstart = i_selector_start;
                    n_send   = s_end;
                    n_last   = last_pos;
                    n_fv     = '0;
                    n_sv     = '0;
                    n_match  = i_selector_match;
                    n_gn     = i_gain;
                    n_bias   = i_bias;
                    n_good   = rng_ok;
                end
            end
            csfd_pkg::ST_SCAN: begin
                n_pos = r_order ? r_pos + 1'b1 : r_pos - 1'b1;
                n_sh  = r_order ? {1'b0, r_sh[PW-1:1]} : {r_sh[PW-2:0], 1'b0};
                if (in_f) begin
                    n_first = 1'b0;
                    n_fv    = (r_first && r_fill) ? {PW{scan_bit}} : {r_fv[PW-2:0], scan_bit};
                end
                if (in_s) begin
                    n_sv = {r_sv[PW-2:0], scan_bit};
                end
            end
            csfd_pkg::ST_CHK: begin
                n_good = !mismatch;
                n_acc  = {{(AW - csfd_pkg::BIAS_W){r_bias[csfd_pkg::BIAS_W-1]}}, r_bias};
                n_mc   = {{(AW - PW){r_fv[PW-1]}}, r_fv};
                n_cnt  = '0;
            end
            csfd_pkg::ST_MUL: begin
                // gain MSB carries negative weight
                n_acc = (r_cnt == csfd_pkg::CNT_LAST) ? r_acc - addend : r_acc + addend;
                n_mc  = {r_mc[AW-2:0], 1'b0};
                n_gn  = {1'b0, r_gn[csfd_pkg::GAIN_W-1:1]};
                n_cnt = r_cnt + 1'b1;
            end
            csfd_pkg::ST_DONE: begin
                if (out_load) begin
                    n_out_valid  = 1'b1;
                    n_out_ok     = r_good;
                    n_out_raw    = r_good ? r_fv : '0;
                    n_out_scaled = r_good ? sat_val : '0;
                end
            end
            default: begin
                n_good = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csfd_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_ok     <= n_out_ok;
        r_out_raw    <= n_out_raw;
        r_out_scaled <= n_out_scaled;
        r_pos        <= n_pos;
        r_sh         <= n_sh;
        r_order      <= n_order;
        r_fill       <= n_fill;
        r_first      <= n_first;
        r_fstart     <= n_fstart;
        r_fend       <= n_fend;
        r_mux        <= n_mux;
        r_sstart     <= n_sstart;
        r_send       <= n_send;
        r_last       <= n_last;
        r_fv         <= n_fv;
        r_sv         <= n_sv;
        r_match      <= n_match;
        r_gn         <= n_gn;
        r_bias       <= n_bias;
        r_acc        <= n_acc;
        r_mc         <= n_mc;
        r_cnt        <= n_cnt;
        r_good       <= n_good;
    end

endmodule
